// File: rtl/core/sih_pkg.sv
// Package for the symbol intern hash table unit.
// Holds the hash width and the back-end state enum.
`default_nettype none
package sih_pkg;
  localparam int unsigned HashW = 32;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_MOD,
    BK_HOME,
    BK_READ,
    BK_CMP,
    BK_WRITE,
    BK_DONE
  } bk_state_e;
endpackage
`default_nettype wire

// File: rtl/core/sih_front.sv
// Front end: takes name bytes, updates the PJW hash, buffers the name.
// Depends on sih_pkg.
`default_nettype none
module sih_front #(
  parameter int unsigned MAX_LEN = 32,
  parameter int unsigned CW = 7,
  parameter int unsigned AW = 5
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          take_i,
  input  wire logic [7:0]    byte_i,
  input  wire logic          last_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output logic      [7:0]    rd_data_o,
  output logic               done_o,
  output logic [sih_pkg::HashW-1:0] hash_o,
  output logic [CW-1:0]      len_o,
  output logic               ovf_o
);
  logic [sih_pkg::HashW-1:0] hash_q, h1, h2;
  logic [CW-1:0] cnt_q;
  logic ovf_q;
  logic [7:0] buf_q [MAX_LEN];

  function automatic logic [31:0] feed(input logic [31:0] h, input logic [7:0] c);
    logic [31:0] t;
    logic [31:0] g;
    t = (h << 4) + {24'd0, c};
    g = t & 32'hF000_0000;
    return t ^ (g | (g >> 24));
  endfunction

  assign h1 = feed(hash_q, byte_i);
  assign h2 = feed(h1, byte_i);

  // hash, count and overflow; cleared after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= '0;
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
      done_o <= 1'b0;
      hash_o <= '0;
      len_o  <= '0;
      ovf_o  <= 1'b0;
    end else begin
      done_o <= take_i && last_i;
      if (take_i) begin
        if (last_i) begin
          hash_o <= h2;
          ovf_o  <= ovf_q || (cnt_q == CW'(MAX_LEN));
          len_o  <= (cnt_q == CW'(MAX_LEN)) ? cnt_q : cnt_q + CW'(1);
          hash_q <= '0;
          cnt_q  <= '0;
          ovf_q  <= 1'b0;
        end else begin
          hash_q <= h1;
          if (cnt_q == CW'(MAX_LEN)) ovf_q <= 1'b1;
          else cnt_q <= cnt_q + CW'(1);
        end
      end
    end
  end

  // name buffer
  always_ff @(posedge clk_i) begin
    if (take_i && cnt_q != CW'(MAX_LEN)) buf_q[cnt_q[AW-1:0]] <= byte_i;
    rd_data_o <= buf_q[rd_addr_i];
  end
endmodule
`default_nettype wire

// File: rtl/core/sih_back.sv
// Back end: modulo, linear probe, compare and insert into the slot table.
// Depends on sih_pkg.
`default_nettype none
module sih_back #(
  parameter int unsigned TABLE_SIZE = 1021,
  parameter int unsigned MAX_LEN = 32,
  parameter int unsigned CW = 7,
  parameter int unsigned AW = 5,
  parameter int unsigned SW = 10
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          go_i,
  input  wire logic [sih_pkg::HashW-1:0] hash_i,
  input  wire logic [CW-1:0] len_i,
  input  wire logic          ovf_i,
  output logic [AW-1:0]      rd_addr_o,
  input  wire logic [7:0]    rd_data_i,
  output logic               busy_o,
  output logic               strobe_o,
  output logic [9:0]         slot_index_o,
  output logic               created_o,
  output logic               table_full_o,
  output logic               name_too_long_o
);
  localparam int unsigned MemD = TABLE_SIZE * MAX_LEN;
  localparam int unsigned MW = $clog2(MemD);
  localparam int unsigned RL = $clog2(TABLE_SIZE);
  localparam int unsigned RW = 33;
  localparam int unsigned PW = sih_pkg::HashW + RW;
  localparam int unsigned QW = sih_pkg::HashW - RL + 1;
  // reciprocal of TABLE_SIZE scaled by 2^(32+RL), rounded up: exact quotient
  localparam logic [63:0] RecipFull = ((64'd1 << (sih_pkg::HashW + RL)) +
    64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
  localparam logic [RW-1:0] Recip = RecipFull[RW-1:0];

  sih_pkg::bk_state_e st_q, st_d;
  logic [sih_pkg::HashW-1:0] rem_q;
  logic [QW-1:0] q_q;
  logic [SW-1:0] s_q, home_q;
  logic [CW-1:0] len_q, k_q;
  logic [7:0] sb_q;
  logic [CW-1:0] sl_q;
  logic ok_q;
  logic [CW-1:0] lmem [TABLE_SIZE];
  logic [7:0] bmem [MemD];
  logic [MW-1:0] baddr;
  logic [SW-1:0] s_nx;
  logic [PW-1:0] prod;
  logic [sih_pkg::HashW-1:0] home_w;
  logic mis;

  assign baddr = MW'(s_q * MAX_LEN) + MW'(k_q);
  assign s_nx = (s_q == SW'(TABLE_SIZE - 1)) ? '0 : s_q + SW'(1);
  // during insert the buffer is read one byte ahead
  assign rd_addr_o = (st_q == sih_pkg::BK_WRITE) ? AW'(k_q + CW'(1)) : k_q[AW-1:0];
  assign busy_o = (st_q != sih_pkg::BK_IDLE) || go_i;
  assign prod = PW'(rem_q) * PW'(Recip);
  assign home_w = rem_q - sih_pkg::HashW'(sih_pkg::HashW'(q_q) * sih_pkg::HashW'(TABLE_SIZE));
  // stored length 0 marks an empty slot; bytes are valid only when ok_q
  assign mis = (sl_q != len_q) || (ok_q && sb_q != rd_data_i);

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      sih_pkg::BK_CLEAR: if (s_q == SW'(TABLE_SIZE - 1)) st_d = sih_pkg::BK_IDLE;
      sih_pkg::BK_IDLE:  if (go_i) st_d = ovf_i ? sih_pkg::BK_DONE : sih_pkg::BK_MOD;
      sih_pkg::BK_MOD:   st_d = sih_pkg::BK_HOME;
      sih_pkg::BK_HOME:  st_d = sih_pkg::BK_READ;
      sih_pkg::BK_READ:  st_d = sih_pkg::BK_CMP;
      sih_pkg::BK_CMP: begin
        if (sl_q == '0) st_d = sih_pkg::BK_WRITE;
        else if (mis) st_d = (s_nx == home_q) ? sih_pkg::BK_DONE : sih_pkg::BK_READ;
        else if (ok_q && k_q + CW'(1) == len_q) st_d = sih_pkg::BK_DONE;
      end
      sih_pkg::BK_WRITE: if (k_q + CW'(1) == len_q) st_d = sih_pkg::BK_DONE;
      sih_pkg::BK_DONE:  st_d = sih_pkg::BK_IDLE;
      default:           st_d = sih_pkg::BK_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= sih_pkg::BK_CLEAR;
      strobe_o <= 1'b0;
      slot_index_o <= '0;
      created_o <= 1'b0;
      table_full_o <= 1'b0;
      name_too_long_o <= 1'b0;
      rem_q <= '0;
      q_q <= '0;
      s_q <= '0;
      home_q <= '0;
      len_q <= '0;
      k_q <= '0;
      ok_q <= 1'b0;
    end else begin
      st_q <= st_d;
      strobe_o <= (st_q == sih_pkg::BK_DONE);
      case (st_q)
        // clearing pass over the length store after reset
        sih_pkg::BK_CLEAR: s_q <= s_nx;
        sih_pkg::BK_IDLE: if (go_i) begin
          rem_q <= hash_i;
          len_q <= len_i;
          k_q <= '0;
          created_o <= 1'b0;
          table_full_o <= 1'b0;
          name_too_long_o <= ovf_i;
          slot_index_o <= '0;
        end
        // quotient by reciprocal multiply, then remainder
        sih_pkg::BK_MOD: q_q <= prod[sih_pkg::HashW + RL +: QW];
        sih_pkg::BK_HOME: begin
          s_q <= SW'(home_w);
          home_q <= SW'(home_w);
        end
        sih_pkg::BK_READ: begin
          k_q <= '0;
          ok_q <= 1'b0;
        end
        sih_pkg::BK_CMP: begin
          if (sl_q == '0) begin
            ok_q <= 1'b0;
          end else if (mis) begin
            if (s_nx == home_q) table_full_o <= 1'b1;
            else s_q <= s_nx;
            k_q <= '0;
            ok_q <= 1'b0;
          end else if (ok_q) begin
            if (k_q + CW'(1) == len_q) slot_index_o <= 10'(s_q);
            else k_q <= k_q + CW'(1);
            ok_q <= 1'b0;
          end else begin
            ok_q <= 1'b1;
          end
        end
        sih_pkg::BK_WRITE: begin
          k_q <= k_q + CW'(1);
          created_o <= 1'b1;
          slot_index_o <= 10'(s_q);
        end
        default: ;
      endcase
    end
  end

  // slot storage, registered reads
  always_ff @(posedge clk_i) begin
    if (st_q == sih_pkg::BK_CLEAR) begin
      lmem[s_q] <= '0;
    end else if (st_q == sih_pkg::BK_WRITE) begin
      bmem[baddr] <= rd_data_i;
      if (k_q == '0) lmem[s_q] <= len_q;
    end
    sb_q <= bmem[baddr];
    sl_q <= lmem[s_q];
  end

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $countones({created_o, table_full_o, name_too_long_o}) <= 1)
    else $error("conflicting result flags");
  a_full_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && table_full_o |-> slot_index_o == '0)
    else $error("full result with nonzero slot");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(busy_o))
    else $error("result without work");
endmodule
`default_nettype wire

// File: rtl/core/symbol_intern_hash_table_unit.sv
// Top level of the symbol intern hash table unit.
// Depends on sih_pkg, sih_front, sih_back.
//   channel  dir  ports
//   request  in   start_i, busy_o, name_byte_i, last_byte_i
//   result   out  result_valid_o, slot_index_o, created_o, table_full_o, name_too_long_o
// A byte is taken while start_i is high and busy_o low. After the last byte: a hand-off
// to the back end, reciprocal modulo, then per probed slot a read and a length
// check that stops at an empty slot or a length miss, else a compare of each byte; an
// insert writes one byte a cycle, then the result is flagged. busy_o is
// high meanwhile; a too-long name skips the probe and goes straight to its strobe.
// Reset clears hash and counters at once, then a pass over all TABLE_SIZE slots clears
// the slot lengths with busy_o high. The receiver cannot stall.
`default_nettype none
module symbol_intern_hash_table_unit #(
  parameter int unsigned TABLE_SIZE = 1021,
  parameter int unsigned MAX_LEN = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  output logic            busy_o,
  input  wire logic [7:0] name_byte_i,
  input  wire logic       last_byte_i,
  output logic            result_valid_o,
  output logic [9:0]      slot_index_o,
  output logic            created_o,
  output logic            table_full_o,
  output logic            name_too_long_o
);
  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned SW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

  logic take, done;
  logic [sih_pkg::HashW-1:0] hash;
  logic [CW-1:0] len;
  logic ovf;
  logic [AW-1:0] ra;
  logic [7:0] rd;

  assign take = start_i && !busy_o;

  sih_front #(.MAX_LEN(MAX_LEN), .CW(CW), .AW(AW)) u_front (
    .clk_i, .rst_ni, .take_i(take), .byte_i(name_byte_i), .last_i(last_byte_i),
    .rd_addr_i(ra), .rd_data_o(rd), .done_o(done), .hash_o(hash), .len_o(len),
    .ovf_o(ovf)
  );

  sih_back #(.TABLE_SIZE(TABLE_SIZE), .MAX_LEN(MAX_LEN), .CW(CW), .AW(AW), .SW(SW)) u_back (
    .clk_i, .rst_ni, .go_i(done), .hash_i(hash), .len_i(len), .ovf_i(ovf),
    .rd_addr_o(ra), .rd_data_i(rd), .busy_o(busy_o), .strobe_o(result_valid_o),
    .slot_index_o, .created_o, .table_full_o, .name_too_long_o
  );
endmodule
`default_nettype wire

// File: dv/testbench.sv
// Testbench for symbol_intern_hash_table_unit: streams names a byte at a time and
// checks each find/insert result against an in-bench model of the intern table.
// Depends on the RTL top level only; TABLE_SIZE and MAX_LEN stay at their defaults.
`timescale 1ns / 100ps
module testbench;

  localparam int unsigned TableSize = 1021;
  localparam int unsigned MaxLen = 32;

  typedef struct packed {
    logic [9:0] slot;
    logic       created;
    logic       full;
    logic       too_long;
  } intern_res_t;

  typedef struct {
    logic [7:0]  b;
    logic        last;
    int          rep;
    bit          typed;
    intern_res_t res;
  } stim_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start_i = 1'b0;
  logic [7:0] name_byte_i = '0;
  logic       last_byte_i = 1'b0;
  logic       busy_o, result_valid_o, created_o, table_full_o, name_too_long_o;
  logic [9:0] slot_index_o;

  symbol_intern_hash_table_unit u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .name_byte_i, .last_byte_i,
    .result_valid_o, .slot_index_o, .created_o, .table_full_o, .name_too_long_o
  );

  always #1 clk_i = ~clk_i;

  // Intern table mirror
  logic [31:0] hash_acc;
  logic [7:0]  cur_name[MaxLen];
  int          cur_len;
  bit          cur_over;
  bit          occ[TableSize];
  int          occ_len[TableSize];
  logic [7:0]  occ_bytes[TableSize][MaxLen];
  int          occ_count;
  intern_res_t lookup_q[$];
  int          n_items, n_created, n_found, n_full, n_long;
  int          mismatches;
  int          burst_left;

  function automatic logic [31:0] pjw_step(logic [31:0] h, logic [7:0] c);
    logic [31:0] g;
    h = (h << 4) + 32'(c);
    g = h & 32'hf000_0000;
    if (g != 0) h = h ^ (g | (g >> 24));
    return h;
  endfunction

  function automatic bit slot_holds_name(int s);
    if (occ_len[s] != cur_len) return 0;
    for (int i = 0; i < cur_len; i++)
      if (occ_bytes[s][i] != cur_name[i]) return 0;
    return 1;
  endfunction

  // Returns 1 when this byte closes a name; r then holds the expected result
  function automatic bit intern_byte(logic [7:0] b, logic last, output intern_res_t r);
    int home, s;
    r = '0;
    hash_acc = pjw_step(hash_acc, b);
    if (cur_len < MaxLen) begin
      cur_name[cur_len] = b;
      cur_len++;
    end else begin
      cur_over = 1;
    end
    if (!last) return 0;
    if (cur_over) begin
      r.too_long = 1;
      n_long++;
    end else begin
      hash_acc = pjw_step(hash_acc, b);
      home = int'(hash_acc % TableSize);
      s = home;
      r.full = 1;
      do begin
        if (!occ[s]) begin
          occ[s] = 1;
          occ_len[s] = cur_len;
          for (int i = 0; i < cur_len; i++) occ_bytes[s][i] = cur_name[i];
          occ_count++;
          r.slot = 10'(s);
          r.created = 1;
          r.full = 0;
          break;
        end
        if (slot_holds_name(s)) begin
          r.slot = 10'(s);
          r.full = 0;
          break;
        end
        s = (s + 1 == TableSize) ? 0 : s + 1;
      end while (s != home);
      if (r.full) n_full++;
      else if (r.created) n_created++;
      else n_found++;
    end
    hash_acc = '0;
    cur_len = 0;
    cur_over = 0;
    return 1;
  endfunction

  // One request: hold start until the block takes it, then idle per burst pattern
  task automatic send_byte(logic [7:0] b, logic last, bit typed = 0,
                           intern_res_t typed_res = '0);
    intern_res_t r;
    start_i <= 1'b1;
    name_byte_i <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (busy_o);
    n_items++;
    if (intern_byte(b, last, r)) lookup_q.push_back(typed ? typed_res : r);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(0, 20);
    end
  endtask

  // Name content is derived from a seed so earlier names can be resent
  function automatic logic [7:0] name_char(logic [31:0] seed, int i);
    logic [31:0] x;
    x = (seed ^ (32'(i) * 32'h9e37_79b9)) * 32'h85eb_ca6b;
    x = x ^ (x >> 13);
    return x[31:24];
  endfunction

  task automatic send_name(int len, logic [31:0] seed);
    for (int i = 0; i < len; i++) send_byte(name_char(seed, i), i == len - 1);
  endtask

  // Result checker: the receiver never stalls, so compare on every strobe
  always @(posedge clk_i) begin
    intern_res_t got, want;
    if (rst_ni && result_valid_o) begin
      got = {slot_index_o, created_o, table_full_o, name_too_long_o};
      if (lookup_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result slot=%0d c=%0b f=%0b l=%0b",
                                       got.slot, got.created, got.full, got.too_long);
      end else begin
        want = lookup_q.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp slot=%0d c=%0b f=%0b l=%0b, got slot=%0d c=%0b f=%0b l=%0b",
                     want.slot, want.created, want.full, want.too_long,
                     got.slot, got.created, got.full, got.too_long);
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    stim_row_t   rows[$];
    int          len, pick;
    logic [31:0] seed;
    logic [31:0] history[$];
    int          hist_len[$];

    hash_acc = '0;
    cur_len = 0;
    cur_over = 0;
    occ_count = 0;
    burst_left = 0;
    foreach (occ[i]) occ[i] = 0;

    // Directed rows: typed results only where the hash is obvious
    rows = '{
      '{8'h00, 1'b1, 1, 1'b1, '{10'd0, 1'b1, 1'b0, 1'b0}},     // zero byte hashes to slot 0
      '{8'h00, 1'b1, 1, 1'b1, '{10'd0, 1'b0, 1'b0, 1'b0}},     // same name found again
      '{8'hff, 1'b1, 1, 1'b1, '{10'd251, 1'b1, 1'b0, 1'b0}},   // all-ones byte
      '{8'hff, 1'b0, 33, 1'b0, '0},                            // 33 bytes, then last
      '{8'h01, 1'b1, 1, 1'b1, '{10'd0, 1'b0, 1'b0, 1'b1}},     // too long, table untouched
      '{8'haa, 1'b1, 32, 1'b0, '0},                            // exactly max length
      '{8'haa, 1'b1, 32, 1'b0, '0},                            // max-length name found
      '{8'h55, 1'b0, 2, 1'b0, '0},
      '{8'h80, 1'b1, 1, 1'b0, '0},
      '{8'h7f, 1'b1, 5, 1'b0, '0},                             // five bytes, hash never reaches the top nibble
      '{8'h00, 1'b1, 2, 1'b0, '0}                              // zero bytes, other length
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[k]) begin
      for (int i = 0; i < rows[k].rep - 1; i++) send_byte(rows[k].b, 1'b0);
      send_byte(rows[k].b, rows[k].last, rows[k].typed, rows[k].res);
    end

    // Random names: mostly short, some resent, a few over the limit
    while (n_items < 200) begin
      pick = $urandom_range(0, 99);
      if (pick < 25 && history.size() > 0) begin
        pick = $urandom_range(0, history.size() - 1);
        send_name(hist_len[pick], history[pick]);
      end else begin
        pick = $urandom_range(0, 99);
        len = (pick < 65) ? $urandom_range(1, 6) :
              (pick < 88) ? $urandom_range(7, 31) :
              (pick < 93) ? 32 : $urandom_range(33, 40);
        seed = $urandom;
        history.push_back(seed);
        hist_len.push_back(len);
        send_name(len, seed);
      end
    end

    // Let the table settle before filling it
    start_i <= 1'b0;
    while (lookup_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);

    // Fill every slot with distinct two-byte names
    for (int k = 0; k < 65536 && occ_count < TableSize; k++) begin
      send_byte(k[15:8], 1'b0);
      send_byte(k[7:0], 1'b1);
    end

    // Full table: old names still found, new ones refused
    for (int k = 0; k < 12; k++) begin
      pick = $urandom_range(0, history.size() - 1);
      send_name(hist_len[pick], history[pick]);
      send_name($urandom_range(1, 8), $urandom);
    end

    start_i <= 1'b0;
    while (lookup_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("%0d bytes sent: %0d names inserted, %0d found, %0d refused full, %0d too long",
             n_items, n_created, n_found, n_full, n_long);
    $display("final occupancy %0d of %0d slots, %0d mismatches", occ_count, TableSize,
             mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
